/* src/primitive_assembly_expander_defines.svh */
// assertion macros shared by the checker
`ifndef PRIMITIVE_ASSEMBLY_EXPANDER_DEFINES_SVH
`define PRIMITIVE_ASSEMBLY_EXPANDER_DEFINES_SVH

// checked only while out of reset
`define PAE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PAE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* src/pae_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pae_pkg;

    localparam int VERTEX_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int HANDLE_BITS     = 32;
    localparam int MODE_BITS       = 4;
    localparam int TOPO_BITS       = 3;
    localparam int KIND_BITS       = 3;
    localparam int STEP_BITS       = 3;
    localparam int POS_BITS        = 2;
    localparam int USER_BITS       = 5;

    localparam logic [MODE_BITS-1:0] MODE_POINTS = 4'd0;
    localparam logic [MODE_BITS-1:0] MODE_LINES  = 4'd1;
    localparam logic [MODE_BITS-1:0] MODE_LSTRIP = 4'd2;
    localparam logic [MODE_BITS-1:0] MODE_LOOP   = 4'd3;
    localparam logic [MODE_BITS-1:0] MODE_TRIS   = 4'd4;
    localparam logic [MODE_BITS-1:0] MODE_TSTRIP = 4'd5;
    localparam logic [MODE_BITS-1:0] MODE_QSTRIP = 4'd6;
    localparam logic [MODE_BITS-1:0] MODE_FAN    = 4'd7;
    localparam logic [MODE_BITS-1:0] MODE_QUADS  = 4'd8;

    localparam logic [TOPO_BITS-1:0] TOPO_POINT_LIST = 3'd0;
    localparam logic [TOPO_BITS-1:0] TOPO_LINE_LIST  = 3'd1;
    localparam logic [TOPO_BITS-1:0] TOPO_LINE_STRIP = 3'd2;
    localparam logic [TOPO_BITS-1:0] TOPO_TRI_LIST   = 3'd3;
    localparam logic [TOPO_BITS-1:0] TOPO_TRI_STRIP  = 3'd4;

    localparam logic [KIND_BITS-1:0] K_NONE = 3'd0;
    localparam logic [KIND_BITS-1:0] K_PASS = 3'd1;
    localparam logic [KIND_BITS-1:0] K_END  = 3'd2;
    localparam logic [KIND_BITS-1:0] K_LOOP = 3'd3;
    localparam logic [KIND_BITS-1:0] K_FAN  = 3'd4;
    localparam logic [KIND_BITS-1:0] K_QUAD = 3'd5;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [TOPO_BITS-1:0] topo;
    } t_job_ctl;

    function automatic logic [TOPO_BITS-1:0] topo_of(input logic [MODE_BITS-1:0] mode);
        logic [TOPO_BITS-1:0] t;
        unique case (mode)
            MODE_POINTS: t = TOPO_POINT_LIST;
            MODE_LINES:  t = TOPO_LINE_LIST;
            MODE_LSTRIP: t = TOPO_LINE_STRIP;
            MODE_LOOP:   t = TOPO_LINE_STRIP;
            MODE_TRIS:   t = TOPO_TRI_LIST;
            MODE_TSTRIP: t = TOPO_TRI_STRIP;
            MODE_QSTRIP: t = TOPO_TRI_STRIP;
            default:     t = TOPO_TRI_LIST;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

/* src/pae_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module pae_front import pae_pkg::*; #(
    parameter int VERTEX_BITS = VERTEX_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    input  wire logic [MODE_BITS-1:0]   i_cfg_data,
    input  wire logic                   i_item_valid,
    input  wire logic                   i_cmd,
    input  wire logic [HANDLE_BITS-1:0] i_handle,
    output logic                        o_item_ready,
    input  wire logic                   i_push_ready,
    output logic                        o_push_valid,
    output t_job_ctl                    o_ctl,
    output logic [VERTEX_BITS-1:0]      o_va,
    output logic [VERTEX_BITS-1:0]      o_vb,
    output logic [VERTEX_BITS-1:0]      o_vc,
    output logic [VERTEX_BITS-1:0]      o_vd
);

    logic [MODE_BITS-1:0]   r_mode;
    logic [POS_BITS-1:0]    r_span_pos;
    logic [POS_BITS-1:0]    n_span_pos;
    logic [VERTEX_BITS-1:0] r_first;
    logic [VERTEX_BITS-1:0] r_prev;
    logic [VERTEX_BITS-1:0] r_quad0;
    logic [VERTEX_BITS-1:0] r_quad1;
    logic [VERTEX_BITS-1:0] r_quad2;
    logic [VERTEX_BITS-1:0] v;
    logic [KIND_BITS-1:0]   kind;
    logic                   take;
    logic                   pass_mode;

    assign v            = VERTEX_BITS'(i_handle);
    assign take         = i_item_valid & i_push_ready;
    assign o_item_ready = i_push_ready;
    assign pass_mode    = (r_mode <= MODE_QSTRIP);

    always_comb begin
        kind       = K_NONE;
        o_va       = r_first;
        o_vb       = r_prev;
        o_vc       = v;
        o_vd       = v;
        n_span_pos = r_span_pos;
        priority if (i_cmd) begin
            kind       = (r_mode == MODE_LOOP && r_span_pos >= 2'd2) ? K_LOOP : K_END;
            n_span_pos = '0;
        end else if (pass_mode) begin
            kind = K_PASS;
            o_va = v;
            if (r_span_pos != 2'd3) begin
                n_span_pos = r_span_pos + 2'd1;
            end
        end else if (r_mode == MODE_FAN) begin
            if (r_span_pos >= 2'd2) begin
                kind       = K_FAN;
                n_span_pos = 2'd3;
            end else begin
                n_span_pos = r_span_pos + 2'd1;
            end
        end else if (r_mode == MODE_QUADS) begin
            if (r_span_pos == 2'd3) begin
                kind       = K_QUAD;
                o_va       = r_quad0;
                o_vb       = r_quad1;
                o_vc       = r_quad2;
                n_span_pos = '0;
            end else begin
                n_span_pos = r_span_pos + 2'd1;
            end
        end else begin
            // unknown modes drop every vertex
            kind = K_NONE;
        end
    end

    assign o_ctl.kind   = kind;
    assign o_ctl.topo   = topo_of(r_mode);
    assign o_push_valid = i_item_valid & (kind != K_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_TRIS;
            r_span_pos <= '0;
        end else if (i_cfg_valid) begin
            r_mode     <= i_cfg_data;
            r_span_pos <= '0;
        end else if (take) begin
            r_span_pos <= n_span_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && !i_cmd) begin
            if ((pass_mode || r_mode == MODE_FAN) && r_span_pos == 2'd0) begin
                r_first <= v;
            end
            if (r_mode == MODE_FAN && r_span_pos != 2'd0) begin
                r_prev <= v;
            end
            if (r_mode == MODE_QUADS) begin
                if (r_span_pos == 2'd0) begin
                    r_quad0 <= v;
                end
                if (r_span_pos == 2'd1) begin
                    r_quad1 <= v;
                end
                if (r_span_pos == 2'd2) begin
                    r_quad2 <= v;
                end
            end
        end
    end

endmodule
`default_nettype wire

/* src/pae_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module pae_queue import pae_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_ready,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data,
    input  wire logic             i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push & o_ready;
    assign pop_ok  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

/* src/pae_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module pae_back import pae_pkg::*; #(
    parameter int VERTEX_BITS = VERTEX_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_job_valid,
    input  wire t_job_ctl               i_ctl,
    input  wire logic [VERTEX_BITS-1:0] i_va,
    input  wire logic [VERTEX_BITS-1:0] i_vb,
    input  wire logic [VERTEX_BITS-1:0] i_vc,
    input  wire logic [VERTEX_BITS-1:0] i_vd,
    output logic                        o_job_pop,
    output logic                        o_m_valid,
    input  wire logic                   i_m_ready,
    output logic [HANDLE_BITS-1:0]      o_m_vertex,
    output logic [USER_BITS-1:0]        o_m_user,
    output logic                        o_m_last
);

    logic [STEP_BITS-1:0]   r_step;
    logic                   r_valid;
    logic [HANDLE_BITS-1:0] r_vertex;
    logic [USER_BITS-1:0]   r_user;
    logic                   r_last;
    logic [VERTEX_BITS-1:0] sel;
    logic                   has;
    logic                   endm;
    logic                   fin;
    logic                   load;

    always_comb begin
        sel  = '0;
        has  = 1'b1;
        endm = 1'b0;
        fin  = 1'b0;
        unique case (i_ctl.kind)
            K_PASS: begin
                sel = i_va;
                fin = 1'b1;
            end
            K_END: begin
                has  = 1'b0;
                endm = 1'b1;
                fin  = 1'b1;
            end
            K_LOOP: begin
                if (r_step == '0) begin
                    sel = i_va;
                end else begin
                    has  = 1'b0;
                    endm = 1'b1;
                    fin  = 1'b1;
                end
            end
            K_FAN: begin
                unique case (r_step)
                    3'd0:    sel = i_va;
                    3'd1:    sel = i_vb;
                    default: sel = i_vc;
                endcase
                fin = (r_step == 3'd2);
            end
            K_QUAD: begin
                unique case (r_step)
                    3'd0:    sel = i_va;
                    3'd1:    sel = i_vb;
                    3'd2:    sel = i_vc;
                    3'd3:    sel = i_va;
                    3'd4:    sel = i_vc;
                    default: sel = i_vd;
                endcase
                fin = (r_step == 3'd5);
            end
            default: begin
                has = 1'b0;
                fin = 1'b1;
            end
        endcase
    end

    assign load      = i_job_valid & (!r_valid | i_m_ready);
    assign o_job_pop = load & fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_step  <= fin ? '0 : r_step + 1'b1;
            end else if (i_m_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_vertex <= HANDLE_BITS'(sel);
            r_user   <= {endm, i_ctl.topo, has};
            r_last   <= fin;
        end
    end

    assign o_m_valid  = r_valid;
    assign o_m_vertex = r_vertex;
    assign o_m_user   = r_user;
    assign o_m_last   = r_last;

endmodule
`default_nettype wire

/* src/primitive_assembly_expander.sv */
// the first result of an item passes the job queue and then the output register
// one result per cycle through the single output register unless the output stalls,
//   so one item per cycle in pass-through modes, 3 results per fan vertex, 6 per quad
// a two-entry job queue lets the front keep taking items while the output is stalled
// reset: synchronous active low; mode returns to triangles, span position and queue clear
`timescale 1ns / 1ps
`default_nettype none
module primitive_assembly_expander import pae_pkg::*; #(
    parameter int VERTEX_BITS = VERTEX_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [MODE_BITS-1:0]   i_cfg_data,   // primitive_mode
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [HANDLE_BITS-1:0] i_s_tdata,    // vertex_handle
    input  wire logic                   i_s_tuser,    // cmd
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [HANDLE_BITS-1:0]      o_m_tdata,    // out_vertex
    output logic [USER_BITS-1:0]        o_m_tuser,    // span_end, topology[2:0], has_vertex
    output logic                        o_m_tlast
);

    localparam int QW = 4 * VERTEX_BITS + $bits(t_job_ctl);

    t_job_ctl               f_ctl;
    t_job_ctl               q_ctl;
    logic [VERTEX_BITS-1:0] f_va, f_vb, f_vc, f_vd;
    logic [VERTEX_BITS-1:0] q_va, q_vb, q_vc, q_vd;
    logic                   push_valid;
    logic                   push_ready;
    logic                   job_valid;
    logic                   job_pop;
    logic [QW-1:0]          q_out;

    assign o_cfg_ready = 1'b1;

    pae_front #(
        .VERTEX_BITS(VERTEX_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (i_s_tvalid),
        .i_cmd        (i_s_tuser),
        .i_handle     (i_s_tdata),
        .o_item_ready (o_s_tready),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_ctl        (f_ctl),
        .o_va         (f_va),
        .o_vb         (f_vb),
        .o_vc         (f_vc),
        .o_vd         (f_vd)
    );

    pae_queue #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_valid),
        .i_data  ({f_ctl, f_va, f_vb, f_vc, f_vd}),
        .o_ready (push_ready),
        .o_valid (job_valid),
        .o_data  (q_out),
        .i_pop   (job_pop)
    );

    assign {q_ctl, q_va, q_vb, q_vc, q_vd} = q_out;

    pae_back #(
        .VERTEX_BITS(VERTEX_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_ctl       (q_ctl),
        .i_va        (q_va),
        .i_vb        (q_vb),
        .i_vc        (q_vc),
        .i_vd        (q_vd),
        .o_job_pop   (job_pop),
        .o_m_valid   (o_m_tvalid),
        .i_m_ready   (i_m_tready),
        .o_m_vertex  (o_m_tdata),
        .o_m_user    (o_m_tuser),
        .o_m_last    (o_m_tlast)
    );

endmodule
`default_nettype wire

/* src/pae_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "primitive_assembly_expander_defines.svh"
module pae_checker import pae_pkg::*; (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_m_tvalid,
    input wire logic                   i_m_tready,
    input wire logic [HANDLE_BITS-1:0] o_m_tdata,
    input wire logic [USER_BITS-1:0]   o_m_tuser,
    input wire logic                   o_m_tlast
);

    `PAE_ASSERT(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "output item changed while stalled")
    `PAE_ASSERT(a_marker_last, o_m_tvalid && o_m_tuser[4] |-> o_m_tlast, "span end marker not last")
    `PAE_ASSERT(a_marker_bare, o_m_tvalid && o_m_tuser[4] |-> !o_m_tuser[0], "span end marker carries a vertex")
    `PAE_ASSERT(a_bare_zero, o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata == '0, "bare item with nonzero vertex")
    `PAE_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_m_tvalid, "output valid right after reset")

endmodule

bind primitive_assembly_expander pae_checker u_pae_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
`default_nettype wire

/* verif/primitive_assembly_expander_tb.sv */
`timescale 1ns / 1ps
module primitive_assembly_expander_tb;
    import pae_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 20;
    localparam int RX_HOLD_CYCLES = 120;

    localparam logic [MODE_BITS-1:0] MODE_UNKNOWN_LO = 4'd9;
    localparam logic [MODE_BITS-1:0] MODE_UNKNOWN_HI = 4'd15;

    localparam logic CMD_VERTEX   = 1'b0;
    localparam logic CMD_SPAN_END = 1'b1;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] vertex;
        logic                   has_vertex;
        logic [TOPO_BITS-1:0]   topo;
        logic                   span_end;
        logic                   last;
    } t_draw_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [MODE_BITS-1:0]   cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [HANDLE_BITS-1:0] s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [HANDLE_BITS-1:0] m_tdata;
    logic [USER_BITS-1:0]   m_tuser;
    logic                   m_tlast;

    // predictor state
    logic [MODE_BITS-1:0]   cur_mode = MODE_TRIS;
    logic [HANDLE_BITS-1:0] first_vtx = '0;
    logic [HANDLE_BITS-1:0] prev_vtx = '0;
    logic [HANDLE_BITS-1:0] quad_vtx [3];
    int unsigned            span_pos = 0;
    t_draw_result           draw_q [$];

    int  err_count = 0;
    int  items_sent = 0;
    bit  idle_on = 1'b1;
    int  hold_seq = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  rx_gap_left = 0;

    primitive_assembly_expander u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic logic [TOPO_BITS-1:0] topo_for_mode(input logic [MODE_BITS-1:0] mode);
        case (mode)
            MODE_POINTS:              return TOPO_POINT_LIST;
            MODE_LINES:               return TOPO_LINE_LIST;
            MODE_LSTRIP, MODE_LOOP:   return TOPO_LINE_STRIP;
            MODE_TSTRIP, MODE_QSTRIP: return TOPO_TRI_STRIP;
            default:                  return TOPO_TRI_LIST;
        endcase
    endfunction

    task automatic queue_result(input logic [HANDLE_BITS-1:0] v, input logic hv,
                                input logic [TOPO_BITS-1:0] topo, input logic span_end);
        t_draw_result r;
        r.vertex     = v;
        r.has_vertex = hv;
        r.topo       = topo;
        r.span_end   = span_end;
        r.last       = 1'b0;
        draw_q.insert(draw_q.size(), r);
    endtask

    // expected draw-list results for one accepted item
    task automatic expand_item(input logic cmd, input logic [HANDLE_BITS-1:0] v);
        logic [TOPO_BITS-1:0] topo;
        int                   n_before;
        topo = topo_for_mode(cur_mode);
        n_before = draw_q.size();
        if (cmd == CMD_SPAN_END) begin
            if (cur_mode == MODE_LOOP && span_pos >= 2)
                queue_result(first_vtx, 1'b1, topo, 1'b0);
            queue_result('0, 1'b0, topo, 1'b1);
            span_pos = 0;
        end else if (cur_mode <= MODE_QSTRIP) begin
            if (span_pos == 0)
                first_vtx = v;
            if (span_pos < 3)
                span_pos++;
            queue_result(v, 1'b1, topo, 1'b0);
        end else if (cur_mode == MODE_FAN) begin
            if (span_pos == 0) begin
                first_vtx = v;
                span_pos = 1;
            end else if (span_pos == 1) begin
                prev_vtx = v;
                span_pos = 2;
            end else begin
                queue_result(first_vtx, 1'b1, topo, 1'b0);
                queue_result(prev_vtx, 1'b1, topo, 1'b0);
                queue_result(v, 1'b1, topo, 1'b0);
                prev_vtx = v;
                span_pos = 3;
            end
        end else if (cur_mode == MODE_QUADS) begin
            if (span_pos < 3) begin
                quad_vtx[span_pos] = v;
                span_pos++;
            end else begin
                queue_result(quad_vtx[0], 1'b1, topo, 1'b0);
                queue_result(quad_vtx[1], 1'b1, topo, 1'b0);
                queue_result(quad_vtx[2], 1'b1, topo, 1'b0);
                queue_result(quad_vtx[0], 1'b1, topo, 1'b0);
                queue_result(quad_vtx[2], 1'b1, topo, 1'b0);
                queue_result(v, 1'b1, topo, 1'b0);
                span_pos = 0;
            end
        end
        if (draw_q.size() > n_before)
            draw_q[draw_q.size() - 1].last = 1'b1;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
        err_count++;
    endtask

    // input accept, config accept and result check, all sampled at the edge
    always @(posedge i_clk) begin
        t_draw_result e;
        if (i_rst_n) begin
            if (cfg_valid && cfg_ready) begin
                cur_mode = cfg_data;
                span_pos = 0;
            end
            if (s_tvalid && s_tready)
                expand_item(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (draw_q.size() == 0) begin
                    report_mismatch("unexpected result, vertex", m_tdata, '0);
                end else begin
                    e = draw_q.pop_front();
                    if (m_tdata !== e.vertex)
                        report_mismatch("out_vertex", m_tdata, e.vertex);
                    if (m_tuser[0] !== e.has_vertex)
                        report_mismatch("has_vertex", m_tuser[0], e.has_vertex);
                    if (m_tuser[3:1] !== e.topo)
                        report_mismatch("topology", m_tuser[3:1], e.topo);
                    if (m_tuser[4] !== e.span_end)
                        report_mismatch("span_end", m_tuser[4], e.span_end);
                    if (m_tlast !== e.last)
                        report_mismatch("last", m_tlast, e.last);
                end
            end
        end
    end

    // output ready: random stall bursts plus the long hold-off on request
    always @(posedge i_clk) begin
        if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = RX_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (rx_gap_left > 0) begin
            rx_gap_left--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rx_gap_left = $urandom_range(1, 4) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [HANDLE_BITS-1:0] pick_handle();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // valid stays up after the handshake; the next send lowers it only for a random idle gap, a drain lowers it
    task automatic send_item(input logic cmd, input logic [HANDLE_BITS-1:0] handle);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= handle;
        s_tuser  <= cmd;
        do @(posedge i_clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_span(input int n_vtx);
        for (int i = 0; i < n_vtx; i++)
            send_item(CMD_VERTEX, pick_handle());
        send_item(CMD_SPAN_END, $urandom);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (draw_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [MODE_BITS-1:0] mode);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        write_mode(MODE_POINTS);
        send_item(CMD_VERTEX, '0);
        send_item(CMD_VERTEX, '1);
        send_item(CMD_SPAN_END, '1);
        // loop closure, then a loop too short to close
        write_mode(MODE_LOOP);
        send_span(3);
        send_item(CMD_VERTEX, $urandom);
        send_item(CMD_SPAN_END, '0);
        // short fan, full fan, then a span cut by a mode write
        write_mode(MODE_FAN);
        send_span(2);
        send_span(4);
        send_item(CMD_VERTEX, $urandom);
        send_item(CMD_VERTEX, $urandom);
        write_mode(MODE_FAN);
        send_item(CMD_VERTEX, $urandom);
        send_item(CMD_SPAN_END, $urandom);
        // one whole quad and a dropped leftover
        write_mode(MODE_QUADS);
        send_span(5);
        write_mode(MODE_UNKNOWN_HI);
        send_span(1);
    endtask

    task automatic test_random_spans();
        int start;
        int budget;
        for (int p = 0; p < 16; p++) begin
            write_mode(MODE_BITS'(p));
            budget = (p >= MODE_UNKNOWN_LO) ? 6 : 18;
            start = items_sent;
            while (items_sent - start < budget) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(logic'($urandom_range(0, 1)), pick_handle());
                else
                    send_span($urandom_range(0, 9));
            end
        end
    endtask

    task automatic test_output_backpressure();
        write_mode(MODE_FAN);
        hold_seq++;
        send_span(12);
        send_span(10);
        write_mode(MODE_QUADS);
        hold_seq++;
        send_span(9);
    endtask

    task automatic test_drain_pause();
        write_mode(MODE_LOOP);
        send_span(6);
        send_item(CMD_VERTEX, pick_handle());
        send_item(CMD_VERTEX, pick_handle());
        wait_drained();
        send_item(CMD_VERTEX, pick_handle());
        send_item(CMD_SPAN_END, $urandom);
        send_span($urandom_range(0, 4));
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        write_mode(MODE_TSTRIP);
        send_span(8);
        send_span(7);
        write_mode(MODE_QUADS);
        send_span(12);
        send_span(4);
        wait_drained();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_spans();
        test_output_backpressure();
        test_drain_pause();
        test_no_idle();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/pae_pkg.sv
src/pae_front.sv
src/pae_queue.sv
src/pae_back.sv
src/primitive_assembly_expander.sv
src/pae_checker.sv
verif/primitive_assembly_expander_tb.sv
